// ===== design/beqar_pkg.sv =====
package beqar_pkg;

  localparam int unsigned PINS_W   = 4;
  localparam int unsigned NOW_W    = 32;
  localparam int unsigned DELAY_W  = 16;
  localparam int unsigned BTN_W    = 3;
  localparam int unsigned COUNT_W  = 3;
  localparam int unsigned IDX_W    = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [DELAY_W-1:0] FIRST_WAIT_RST = 16'd300;
  localparam logic [DELAY_W-1:0] REP_WAIT_RST   = 16'd150;

  localparam logic signed [BTN_W-1:0] BTN_NONE = -3'sd1;

  // register map of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_WAIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REP_WAIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 2'd2;

  typedef enum logic [1:0] {
    OP_PIN_CHANGE = 2'd0,
    OP_POP        = 2'd1,
    OP_POLL       = 2'd2,
    OP_NONE       = 2'd3
  } op_e;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
  } single_t;

  // queue commands from the control logic
  typedef struct packed {
    logic             push;
    logic             pop;
    logic [IDX_W-1:0] data;
  } q_ctrl_t;

  // queue state seen by the control logic
  typedef struct packed {
    logic             full;
    logic             empty;
    logic [IDX_W-1:0] head;
  } q_stat_t;

  function automatic single_t single_button(input logic [PINS_W-1:0] pins);
    single_t res;
    res = '0;
    case (pins)
      4'b0001: res = '{hit: 1'b1, idx: 2'd0};
      4'b0010: res = '{hit: 1'b1, idx: 2'd1};
      4'b0100: res = '{hit: 1'b1, idx: 2'd2};
      4'b1000: res = '{hit: 1'b1, idx: 2'd3};
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

// ===== design/beqar_if.sv =====
interface beqar_in_if;
  import beqar_pkg::*;

  logic                valid;
  logic                ready;
  op_e                 operation;
  logic [PINS_W-1:0]   pins;
  logic [NOW_W-1:0]    now;

  modport source (output valid, operation, pins, now, input ready);
  modport sink   (input valid, operation, pins, now, output ready);
endinterface

interface beqar_out_if;
  import beqar_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [BTN_W-1:0]  button;
  logic [COUNT_W-1:0]       queue_count;

  modport source (output valid, button, queue_count, input ready);
  modport sink   (input valid, button, queue_count, output ready);
endinterface

// ===== design/button_event_queue_auto_repeat.sv =====
// Four-button key event queue with auto-repeat.
// in_i carries one word per operation: a pin change (queue a single pressed
// button, arm or disarm the repeat timer), a pop of the queue head, or a
// repeat poll against the tick count in now. out_o returns one word for every
// input word, in order: the delivered button index 0..3 or -1 for none, and
// the queue fill after that operation.
// The cfg_* port writes the first repeat wait (0), the repeat interval (1)
// and enable (2); write it only while no word is in flight.
// Path: an accepted word is held in the input register, processed from there
// and its result is held in the result register, which drives out_o.
// Throughput: one word per cycle while out_o is not stalled; all the work is
// one pass of logic between the input register and the result register.
// Stall: while out_o holds a word that is not taken, one more input word is
// taken into the input register, then in_i.ready drops until out_o drains.
// Reset clears the queue, the last pin pattern and the repeat timer, and
// loads the delay and enable registers with their defaults.
module button_event_queue_auto_repeat #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [beqar_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [beqar_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  beqar_in_if.sink                          in_i,
  beqar_out_if.source                       out_o
);
  import beqar_pkg::*;

  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);

  logic                     in_valid_q;
  op_e                      in_op_q;
  logic [PINS_W-1:0]        in_pins_q;
  logic [NOW_W-1:0]         in_now_q;
  logic                     advance;

  logic                     out_valid_q;
  logic signed [BTN_W-1:0]  out_button_q;
  logic [COUNT_W-1:0]       out_count_q;

  q_ctrl_t                  q_ctrl;
  q_stat_t                  q_stat;
  logic [FILL_W-1:0]        fill_next;
  logic signed [BTN_W-1:0]  button;

  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_op_q   <= in_i.operation;
      in_pins_q <= in_i.pins;
      in_now_q  <= in_i.now;
    end
  end

  beqar_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (advance),
    .op_i        (in_op_q),
    .pins_i      (in_pins_q),
    .now_i       (in_now_q),
    .q_stat_i    (q_stat),
    .q_ctrl_o    (q_ctrl),
    .button_o    (button)
  );

  beqar_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .FILL_W      (FILL_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (q_ctrl),
    .stat_o      (q_stat),
    .fill_next_o (fill_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // hold the word until the sink takes it
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_button_q <= button;
      out_count_q  <= COUNT_W'(fill_next);
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.button      = out_button_q;
  assign out_o.queue_count = out_count_q;

endmodule

// ===== design/beqar_queue.sv =====
module beqar_queue #(
  parameter int unsigned QUEUE_DEPTH = 4,
  parameter int unsigned FILL_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  beqar_pkg::q_ctrl_t  ctrl_i,
  output beqar_pkg::q_stat_t  stat_o,
  output logic [FILL_W-1:0]   fill_next_o
);
  import beqar_pkg::*;

  logic [IDX_W-1:0]  entry_q [QUEUE_DEPTH];
  logic [FILL_W-1:0] fill_q, fill_d;

  always_comb begin
    fill_d = fill_q;
    if (ctrl_i.push) begin
      fill_d = fill_q + FILL_W'(1);
    end else if (ctrl_i.pop) begin
      fill_d = fill_q - FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // push writes at the tail, pop shifts every entry one place toward the head
  always_ff @(posedge clk_i) begin
    for (int unsigned i = 0; i < QUEUE_DEPTH; i++) begin
      if (ctrl_i.push && (fill_q == FILL_W'(i))) begin
        entry_q[i] <= ctrl_i.data;
      end else if (ctrl_i.pop && (i + 1 < QUEUE_DEPTH)) begin
        entry_q[i] <= entry_q[(i + 1 < QUEUE_DEPTH) ? i + 1 : i];
      end
    end
  end

  assign stat_o.full  = (fill_q == FILL_W'(QUEUE_DEPTH));
  assign stat_o.empty = (fill_q == '0);
  assign stat_o.head  = entry_q[0];
  assign fill_next_o  = fill_d;

endmodule

// ===== design/beqar_ctrl.sv =====
module beqar_ctrl (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [beqar_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [beqar_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic                                   fire_i,
  input  beqar_pkg::op_e                         op_i,
  input  logic [beqar_pkg::PINS_W-1:0]           pins_i,
  input  logic [beqar_pkg::NOW_W-1:0]            now_i,
  input  beqar_pkg::q_stat_t                     q_stat_i,
  output beqar_pkg::q_ctrl_t                     q_ctrl_o,
  output logic signed [beqar_pkg::BTN_W-1:0]     button_o
);
  import beqar_pkg::*;

  logic [DELAY_W-1:0] first_wait_q;
  logic [DELAY_W-1:0] rep_wait_q;
  logic               enable_q;
  logic [PINS_W-1:0]  last_pins_q, last_pins_d;
  logic [NOW_W-1:0]   due_q, due_d;
  single_t            single;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_wait_q <= FIRST_WAIT_RST;
      rep_wait_q   <= REP_WAIT_RST;
      enable_q     <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FIRST_WAIT: first_wait_q <= cfg_wdata_i[DELAY_W-1:0];
        CFG_REP_WAIT:   rep_wait_q   <= cfg_wdata_i[DELAY_W-1:0];
        CFG_ENABLE:     enable_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign single = single_button(pins_i);

  always_comb begin
    last_pins_d = last_pins_q;
    due_d       = due_q;
    q_ctrl_o    = '{push: 1'b0, pop: 1'b0, data: single.idx};
    button_o    = BTN_NONE;
    if (fire_i) begin
      case (op_i)
        OP_PIN_CHANGE: begin
          if (enable_q) begin
            if (!q_stat_i.full) begin
              if (single.hit) begin
                q_ctrl_o.push = 1'b1;
                due_d = now_i + NOW_W'(first_wait_q);
              end else begin
                due_d = '0;
              end
            end
            last_pins_d = pins_i;
          end
        end
        OP_POP: begin
          if (!q_stat_i.empty) begin
            q_ctrl_o.pop = 1'b1;
            button_o     = signed'({1'b0, q_stat_i.head});
          end
        end
        OP_POLL: begin
          // zero means disarmed
          if (due_q != '0) begin
            if (pins_i != last_pins_q) begin
              due_d = '0;
            end else if (now_i > due_q) begin
              if (single.hit) begin
                due_d    = now_i + NOW_W'(rep_wait_q);
                button_o = signed'({1'b0, single.idx});
              end else begin
                due_d = '0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pins_q <= '0;
      due_q       <= '0;
    end else begin
      last_pins_q <= last_pins_d;
      due_q       <= due_d;
    end
  end

endmodule

// ===== design/beqar_checker.sv =====
module beqar_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic signed [beqar_pkg::BTN_W-1:0] out_button_i,
  input  logic [beqar_pkg::COUNT_W-1:0]     out_count_i
);
  import beqar_pkg::*;

  logic [COUNT_W-1:0] last_count_q;
  logic [COUNT_W-1:0] count_step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_count_q <= '0;
    end else if (out_valid_i && out_ready_i) begin
      last_count_q <= out_count_i;
    end
  end

  assign count_step = out_count_i - last_count_q;

  // a stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_button_i)
      && $stable(out_count_i))
    else $error("output word changed while stalled");

  // only a button index or none is ever delivered
  a_button: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_button_i[BTN_W-1] == 1'b0) || (out_button_i == BTN_NONE))
    else $error("button code out of range");

  // each operation moves the queue fill by at most one entry
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (count_step == COUNT_W'(0)) || (count_step == COUNT_W'(1))
      || (count_step == '1))
    else $error("queue count jumped by more than one");

  // a delivered button always comes with a lower or unchanged count, never a rise
  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_button_i != BTN_NONE) |-> (count_step != COUNT_W'(1)))
    else $error("button delivered while the queue grew");

endmodule

bind button_event_queue_auto_repeat beqar_checker u_beqar_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_button_i (out_o.button),
  .out_count_i  (out_o.queue_count)
);
